FILE: sv/sbfu_pkg.sv
`timescale 1ns / 1ps

package sbfu_pkg;

  localparam int unsigned GROUPS_PER_FRAME = 4;
  localparam int unsigned GROUP_BYTES      = 8;
  localparam int unsigned GROUP_PAYLOAD    = 7;
  localparam int unsigned STORE_DEPTH      = GROUPS_PER_FRAME * GROUP_PAYLOAD;

  localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int unsigned IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned GRP_W = (GROUPS_PER_FRAME > 1) ? $clog2(GROUPS_PER_FRAME) : 1;
  localparam int unsigned POS_W = 3;

  localparam logic [GRP_W-1:0] LAST_GROUP = GRP_W'(GROUPS_PER_FRAME - 1);
  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(GROUP_BYTES - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(STORE_DEPTH);

  localparam logic [7:0] SEVEN_MASK = 8'b0111_1111;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_START_SENTINEL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PAD_SENTINEL   = CFG_IDX_W'(1);

  localparam logic [7:0] START_SENTINEL_RST = 8'd128;
  localparam logic [7:0] PAD_SENTINEL_RST   = 8'd255;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic rd_issue;  // read payload store at drain pointer
    logic load;      // move read data into output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic frame_done;   // accepted byte completes a frame
    logic drain_empty;  // completed frame has nothing to emit
    logic drain_last;   // drain pointer is at the final byte
    logic out_free;     // output register can take a beat
  } dp_status_t;

endpackage

FILE: sv/sbfu_datapath.sv
`timescale 1ns / 1ps

module sbfu_datapath import sbfu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  dp_cmd_t              cmd,
  output dp_status_t           status
);

  logic [7:0]       start_r;
  logic [7:0]       pad_r;

  logic             in_frame_r, in_frame_nxt;
  logic [GRP_W-1:0] grp_r, grp_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       prev_r, prev_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] drain_n_r;
  logic [IDX_W-1:0] rd_ptr_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r;

  logic [7:0]       mem [STORE_DEPTH];
  logic [7:0]       rd_data_r;

  logic [7:0]       cur;
  logic             last;
  logic             hit_start, hit_pad;
  logic [2:0]       b;
  logic [7:0]       hi, lo, unpacked;
  logic             wr_en;
  logic             done;
  logic [CNT_W-1:0] drain_n_nxt;

  assign cur       = in_item.line_byte;
  assign last      = in_item.chunk_end;
  assign hit_start = (cur == start_r);
  assign hit_pad   = (cur == pad_r);

  // big-endian 7-bit unpack: tail of previous byte, head of current one
  assign b        = pos_r - POS_W'(1);
  assign hi       = 8'((prev_r & (SEVEN_MASK >> b)) << ({1'b0, b} + 4'd1));
  assign lo       = (cur & SEVEN_MASK) >> (3'd6 - b);
  assign unpacked = hi | lo;

  always_comb begin
    in_frame_nxt = in_frame_r;
    grp_nxt      = grp_r;
    pos_nxt      = pos_r;
    prev_nxt     = prev_r;
    cnt_nxt      = cnt_r;
    wr_en        = 1'b0;
    done         = 1'b0;
    if (cmd.accept) begin
      priority if (!in_frame_r) begin
        if (hit_start && !last) begin
          in_frame_nxt = 1'b1;
          grp_nxt      = '0;
          pos_nxt      = '0;
          cnt_nxt      = '0;
        end
      end else if (pos_r == '0) begin
        prev_nxt = cur;
        pos_nxt  = POS_W'(1);
        if (last) begin
          in_frame_nxt = 1'b0;
          grp_nxt      = '0;
          pos_nxt      = '0;
          cnt_nxt      = '0;
        end
      end else if (hit_start || hit_pad) begin
        // sentinel inside a frame: drop it, maybe restart
        in_frame_nxt = hit_start && !last;
        grp_nxt      = '0;
        pos_nxt      = '0;
        cnt_nxt      = '0;
      end else begin
        if (cnt_r < DEPTH_CNT) begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        prev_nxt = cur;
        pos_nxt  = pos_r + POS_W'(1);
        if (pos_r == LAST_POS) begin
          pos_nxt = '0;
          if (grp_r == LAST_GROUP) begin
            done = 1'b1;
          end else begin
            grp_nxt = grp_r + GRP_W'(1);
          end
        end
        if (done || last) begin
          in_frame_nxt = 1'b0;
          grp_nxt      = '0;
          pos_nxt      = '0;
        end
      end
    end
  end

  // payload count after this byte, rounded down to a multiple of four
  assign drain_n_nxt = (wr_en ? cnt_r + CNT_W'(1) : cnt_r) & ~CNT_W'(3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      grp_r      <= '0;
      pos_r      <= '0;
      prev_r     <= '0;
      cnt_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      grp_r      <= grp_nxt;
      pos_r      <= pos_nxt;
      prev_r     <= prev_nxt;
      cnt_r      <= (done || (cmd.accept && last)) ? '0 : cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_SENTINEL_RST;
      pad_r   <= PAD_SENTINEL_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_START_SENTINEL) begin
        start_r <= cfg_data;
      end else if (cfg_index == REG_PAD_SENTINEL) begin
        pad_r <= cfg_data;
      end
    end
  end

  // payload store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[IDX_W-1:0]] <= unpacked;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_n_r <= '0;
      rd_ptr_r  <= '0;
    end else if (done) begin
      drain_n_r <= drain_n_nxt;
      rd_ptr_r  <= '0;
    end else if (cmd.load) begin
      rd_ptr_r  <= rd_ptr_r + IDX_W'(1);
    end
  end

  // output register
  assign out_valid_nxt = cmd.load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.payload_byte <= rd_data_r;
      out_r.frame_last   <= status.drain_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign status.frame_done  = done;
  assign status.drain_empty = (drain_n_nxt == '0);
  assign status.drain_last  = ({{(CNT_W - IDX_W){1'b0}}, rd_ptr_r} + CNT_W'(1)) == drain_n_r;
  assign status.out_free    = !out_valid_r || out_ready;

endmodule

FILE: sv/sbfu_ctrl.sv
`timescale 1ns / 1ps

module sbfu_ctrl import sbfu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_READ = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.rd_issue = 1'b0;
    cmd.load     = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.frame_done && !status.drain_empty) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = status.drain_last ? ST_RUN : ST_READ;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/seven_bit_frame_unpacker_unit.sv
`timescale 1ns / 1ps

// Seven-bit frame unpacker. Line bytes come in one beat at a time; after a
// start sentinel, GROUPS_PER_FRAME groups of eight bytes unpack big-endian
// into seven payload bytes each, kept in an internal payload store. Bytes two
// to eight of a group abort the frame if they match either sentinel (a start
// sentinel restarts the frame); chunk_end drops any partial frame. A finished
// frame is emitted as its payload cut down to a multiple of four bytes, with
// frame_last on the final byte. Rate: while no frame is being emitted, one
// line byte is taken every cycle. After the last byte of a frame the input
// stalls while the store drains through its single registered read port;
// each payload byte is read, then loaded into the output register, and the
// load waits out any output stall; with four groups that is 28 bytes.
// The output register lets the next input byte be taken while the final
// payload beat still waits. Configuration: index 0 start sentinel (reset
// 128), index 1 pad sentinel (reset 255); other indexes are ignored.

module seven_bit_frame_unpacker_unit import sbfu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer: input acceptance and frame drain
  sbfu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // framing state, unpack, payload store and output register
  sbfu_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: sim/tb_seven_bit_frame_unpacker_unit.sv
`timescale 1ns / 1ps

module tb_seven_bit_frame_unpacker_unit;
  import sbfu_pkg::*;

  localparam int FRAME_BYTES   = GROUPS_PER_FRAME * GROUP_BYTES;
  localparam int SETTLE_CYCLES = 4;      // idle gap before a register write
  localparam int DRAIN_CYCLES  = 64;     // longer than one full payload drain
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;

  // index outside the register map; the block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = '1;

  typedef enum int {FRAME_CLEAN, FRAME_PAD_ABORT, FRAME_RESTART, FRAME_CUT} frame_kind_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = '0;

  seven_bit_frame_unpacker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle rates in percent, changed between phases by the main sequence.
  int send_idle_pct = 26;
  int recv_idle_pct = 75;

  int unsigned cycle_count   = 0;
  int unsigned error_count   = 0;
  int unsigned beats_checked = 0;
  int unsigned frames_seen   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned frame_bytes   = 0;   // bytes sent inside framed sequences

  // ---------------------------------------------------------------------------
  // Unpacker shadow: sentinels, framing state and the payload buffer, advanced
  // once per accepted line byte. Every payload beat a finished frame must emit
  // is queued in order in expected_payload.
  // ---------------------------------------------------------------------------
  logic [7:0]  start_sent = START_SENTINEL_RST;
  logic [7:0]  pad_sent   = PAD_SENTINEL_RST;
  bit          framing    = 1'b0;
  int unsigned grp_idx    = 0;
  int unsigned byte_pos   = 0;
  int unsigned store_cnt  = 0;
  logic [7:0]  prev_byte  = '0;
  logic [7:0]  payload_buf [STORE_DEPTH];
  out_item_t   expected_payload [$];

  // Both a frame restart and a return to hunting clear the frame counters.
  function automatic void reset_frame(input bit open);
    framing   = open;
    grp_idx   = 0;
    byte_pos  = 0;
    store_cnt = 0;
  endfunction

  function automatic void unpack_line_byte(input in_item_t item);
    logic [7:0]  cur;
    logic [7:0]  hi;
    logic [7:0]  lo;
    int unsigned b;
    int unsigned n;
    out_item_t   exp_beat;
    cur = item.line_byte;
    if (!framing) begin
      // hunting: a start sentinel opens a frame unless it ends the chunk
      if (cur == start_sent && !item.chunk_end) reset_frame(1'b1);
      return;
    end
    if (byte_pos == 0) begin
      // first byte of a group is never compared with the sentinels
      prev_byte = cur;
      byte_pos  = 1;
    end else begin
      if (cur == start_sent || cur == pad_sent) begin
        // start is tested first, so it wins when both sentinels are equal
        reset_frame(cur == start_sent && !item.chunk_end);
        return;
      end
      // big-endian 7-bit unpack: low bits of the previous byte on top,
      // high bits of this one below
      b  = byte_pos - 1;
      hi = (prev_byte & (SEVEN_MASK >> b)) << (b + 1);
      lo = (cur & SEVEN_MASK) >> (6 - b);
      if (store_cnt < STORE_DEPTH) begin
        payload_buf[store_cnt] = hi | lo;
        store_cnt++;
      end
      prev_byte = cur;
      byte_pos++;
      if (byte_pos >= GROUP_BYTES) begin
        byte_pos = 0;
        grp_idx++;
        if (grp_idx >= GROUPS_PER_FRAME) begin
          // frame done: emit a multiple of four bytes, mark the final one
          n = store_cnt & ~3;
          for (int unsigned k = 0; k < n; k++) begin
            exp_beat.payload_byte = payload_buf[k];
            exp_beat.frame_last   = (k + 1 == n);
            expected_payload      = {expected_payload, exp_beat};
          end
          reset_frame(1'b0);
          return;
        end
      end
    end
    if (item.chunk_end) reset_frame(1'b0);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random backpressure and the in-order beat check.
  // ---------------------------------------------------------------------------
  function automatic void note_failure(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_payload.size() == 0) begin
        note_failure($sformatf("unexpected beat: byte %02h last %0b",
                               out_item.payload_byte, out_item.frame_last));
      end else begin
        want = expected_payload[0];
        expected_payload.delete(0);
        if (out_item.payload_byte !== want.payload_byte ||
            out_item.frame_last !== want.frame_last)
          note_failure($sformatf("beat %0d: expected byte %02h last %0b, got byte %02h last %0b",
                                 beats_checked, want.payload_byte, want.frame_last,
                                 out_item.payload_byte, out_item.frame_last));
      end
      beats_checked++;
      if (out_item.frame_last === 1'b1) frames_seen++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still expected",
               cycle_count, expected_payload.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // One line-byte beat. valid stays high after the accept; it only drops when
  // the next beat opens with an idle gap, or when a phase ends.
  task automatic send_line_byte(input logic [7:0] value, input logic last);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{line_byte: value, chunk_end: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    unpack_line_byte('{line_byte: value, chunk_end: last});
    bytes_sent++;
  endtask

  // Random byte that cannot be mistaken for a sentinel.
  function automatic logic [7:0] random_data_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == start_sent || b == pad_sent);
    return b;
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [7:0] value);
    in_valid <= 1'b0;
    while (expected_payload.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (index == REG_START_SENTINEL)    start_sent = value;
    else if (index == REG_PAD_SENTINEL) pad_sent   = value;
  endtask

  // Start sentinel plus a full frame of fixed data: lead on each group's
  // unchecked first byte, fill everywhere else.
  task automatic send_pattern_frame(input logic [7:0] lead, input logic [7:0] fill,
                                    input bit end_mark);
    send_line_byte(start_sent, 1'b0);
    for (int i = 0; i < FRAME_BYTES; i++)
      send_line_byte((i % GROUP_BYTES == 0) ? lead : fill,
                     end_mark && (i == FRAME_BYTES - 1));
  endtask

  // Start sentinel plus frame body with random content, optionally broken
  // at a random point (pad abort, restart, or chunk end).
  task automatic send_frame(input frame_kind_t kind);
    int         stop_at;
    logic [7:0] b;
    stop_at = $urandom_range(1, FRAME_BYTES - 2);
    // aborts must hit a checked byte, not a group's first byte
    if (kind != FRAME_CUT)
      while (stop_at % GROUP_BYTES == 0) stop_at = $urandom_range(1, FRAME_BYTES - 2);
    send_line_byte(start_sent, 1'b0);
    frame_bytes++;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      frame_bytes++;
      if (kind == FRAME_PAD_ABORT && i == stop_at) begin
        send_line_byte(pad_sent, 1'($urandom_range(0, 1)));
        break;
      end
      if (kind == FRAME_RESTART && i == stop_at) begin
        // start sentinel mid-frame: a fresh frame body follows
        send_line_byte(start_sent, 1'b0);
        kind = FRAME_CLEAN;
        i = -1;
        continue;
      end
      if (i % GROUP_BYTES == 0)
        b = ($urandom_range(0, 5) == 0) ? (($urandom_range(0, 1) != 0) ? start_sent : pad_sent)
                                        : 8'($urandom_range(0, 255));
      else
        b = random_data_byte();
      if (kind == FRAME_CUT && i == stop_at) begin
        send_line_byte(b, 1'b1);
        break;
      end
      send_line_byte(b, (i == FRAME_BYTES - 1) && ($urandom_range(0, 1) != 0));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hunting and abort corner cases with reset sentinels.
  task automatic test_framing_cases();
    send_line_byte(start_sent, 1'b1);   // start on a chunk end opens nothing
    send_line_byte(8'h05, 1'b0);        // still hunting
    send_line_byte(start_sent, 1'b0);
    send_line_byte(pad_sent, 1'b0);     // unchecked first byte, just data
    send_line_byte(pad_sent, 1'b0);     // pad on a checked byte: abort
    send_line_byte(start_sent, 1'b0);
    send_line_byte(start_sent, 1'b0);   // unchecked first byte
    send_line_byte(start_sent, 1'b0);   // restart mid-group
    send_line_byte(8'h7F, 1'b0);
    send_line_byte(8'h00, 1'b1);        // chunk end drops the partial frame
    send_line_byte(start_sent, 1'b0);
    send_line_byte(8'h33, 1'b0);
    send_line_byte(start_sent, 1'b1);   // start with chunk end inside a frame
    send_line_byte(8'h01, 1'b0);        // hunting again, ignored
  endtask

  // Data extremes; the second frame has its last byte flagged as chunk end.
  task automatic test_extreme_frames();
    send_pattern_frame(8'h00, 8'h00, 1'b0);
    send_pattern_frame(pad_sent, 8'h7F, 1'b1);
    send_pattern_frame(8'hFE, 8'hFE, 1'b0);
  endtask

  // Mostly whole frames, some broken ones, and bursts of line noise.
  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned target;
    int unsigned pick;
    target = frame_bytes + n_bytes;
    while (frame_bytes < target) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5)      send_frame(FRAME_CLEAN);
      else if (pick == 6) send_frame(FRAME_PAD_ABORT);
      else if (pick == 7) send_frame(FRAME_RESTART);
      else if (pick == 8) send_frame(FRAME_CUT);
      else
        repeat ($urandom_range(1, 6))
          send_line_byte(($urandom_range(0, 3) == 0) ? start_sent : 8'($urandom_range(0, 255)),
                         $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic test_sentinel_setting(input logic [7:0] start_value,
                                       input logic [7:0] pad_value,
                                       input int unsigned n_bytes);
    write_register(REG_START_SENTINEL, start_value);
    write_register(REG_PAD_SENTINEL, pad_value);
    test_random_traffic(n_bytes);
  endtask

  // A write to an unmapped index must leave both sentinels alone.
  task automatic test_unmapped_register();
    write_register(REG_UNMAPPED, 8'($urandom_range(0, 255)));
    send_pattern_frame(8'h2C, 8'h13, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    send_idle_pct = 26;
    recv_idle_pct = 75;
    test_framing_cases();
    test_extreme_frames();
    test_random_traffic(30);
    test_sentinel_setting(8'h00, 8'hFF, 30);

    // roles swapped
    send_idle_pct = 75;
    recv_idle_pct = 26;
    test_sentinel_setting(8'hFF, 8'h00, 30);

    // full rate, both sentinels equal
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_sentinel_setting(8'h5A, 8'h5A, 30);
    test_unmapped_register();

    in_valid <= 1'b0;
    while (expected_payload.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d line bytes over four sentinel settings and three idle mixes;",
             bytes_sent);
    $display("checked %0d payload beats from %0d frames, %0d mismatches.",
             beats_checked, frames_seen, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: seven_bit_frame_unpacker_unit.f
sv/sbfu_pkg.sv
sv/sbfu_datapath.sv
sv/sbfu_ctrl.sv
sv/seven_bit_frame_unpacker_unit.sv
sim/tb_seven_bit_frame_unpacker_unit.sv
